// File: design/ssc_pkg.sv
// shared types, constants and opcode codes for the script signature-op counter
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

    localparam int COUNT_BITS = 20;
    localparam int LIMIT_W    = 20;
    localparam int SIGOP_W    = 20;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(80000);

    // register index, taken from paddr[2]
    localparam logic REG_SIGOP_LIMIT = 1'b0;

    localparam logic [7:0] OP_PUSH_MAX   = 8'h4e;
    localparam logic [7:0] OP_PUSHDATA1  = 8'h4c;
    localparam logic [7:0] OP_CHECKSIG   = 8'hac;
    localparam logic [7:0] OP_CHECKSIGV  = 8'had;
    localparam logic [7:0] OP_CHECKSIGADD = 8'hba;
    localparam logic [7:0] OP_CHECKMS    = 8'hae;
    localparam logic [7:0] OP_CHECKMSV   = 8'haf;
    localparam logic [7:0] OP_SMALL_LO   = 8'h51;
    localparam logic [7:0] OP_SMALL_HI   = 8'h60;
    localparam logic [7:0] OP_SMALL_BASE = 8'h50;
    localparam logic [7:0] OP_NONE       = 8'hff;

    localparam logic [4:0] MULTISIG_DEFAULT = 5'd20;

    typedef enum logic [2:0] {
        PH_OPCODE = 3'b001,
        PH_LENGTH = 3'b010,
        PH_SKIP   = 3'b100
    } t_phase;

    typedef struct packed {
        logic       tapscript_mode;
        logic       accurate_mode;
        logic       byte_present;
        logic       last_byte;
        logic [7:0] script_byte;
    } t_item;

    typedef struct packed {
        logic               limit_exceeded;
        logic [SIGOP_W-1:0] sigop_count;
    } t_result;

endpackage

`default_nettype wire

// File: design/ssc_cfg.sv
// apb register block holding the signature-op limit
`timescale 1ns / 1ps
`default_nettype none

module ssc_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ssc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ssc_pkg::DATA_W-1:0]   pwdata,
    output logic      [ssc_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic      [ssc_pkg::LIMIT_W-1:0]  o_sigop_limit
);
    import ssc_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (wr_en && (paddr[2] == REG_SIGOP_LIMIT)) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_SIGOP_LIMIT) begin
            prdata = DATA_W'(r_limit);
        end else begin
            prdata = '0;
        end
    end

    assign o_sigop_limit = r_limit;

endmodule

`default_nettype wire

// File: design/ssc_parser.sv
// script parser state and signature-op charge logic, one byte per step
`timescale 1ns / 1ps
`default_nettype none

module ssc_parser (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire ssc_pkg::t_item               i_item,
    input  wire logic [ssc_pkg::LIMIT_W-1:0]  i_sigop_limit,
    output ssc_pkg::t_result                  o_result
);
    import ssc_pkg::*;

    localparam int                CW     = COUNT_BITS + 1;
    localparam logic [63:0]       CMAX64 = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [31:0]       CMAX   = CMAX64[31:0];

    t_phase                r_phase,  n_phase;
    logic [2:0]            r_left,   n_left;
    logic [1:0]            r_idx,    n_idx;
    logic [31:0]           r_acc,    n_acc;
    logic [31:0]           r_skip,   n_skip;
    logic [7:0]            r_prev,   n_prev;
    logic [COUNT_BITS-1:0] r_count,  n_count;
    logic                  r_ovf,    n_ovf;

    logic                  chg_req;
    logic [4:0]            chg_amt;
    logic [31:0]           lim32;
    logic [COUNT_BITS-1:0] lim;
    logic [CW-1:0]         sum;
    logic [31:0]           count_wide;
    logic [7:0]            b;

    assign b     = i_item.script_byte;
    assign lim32 = (32'(i_sigop_limit) < CMAX) ? 32'(i_sigop_limit) : CMAX;
    assign lim   = lim32[COUNT_BITS-1:0];
    assign sum   = {1'b0, r_count} + CW'(chg_amt);

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_idx   = r_idx;
        n_acc   = r_acc;
        n_skip  = r_skip;
        n_prev  = r_prev;
        n_count = r_count;
        n_ovf   = r_ovf;
        chg_req = 1'b0;
        chg_amt = 5'd1;
        if (i_item.byte_present) begin
            case (r_phase)
                PH_LENGTH: begin
                    n_acc[{r_idx, 3'b000} +: 8] = b;
                    n_idx = r_idx + 2'd1;
                    if (r_left != 3'd0) begin
                        n_left = r_left - 3'd1;
                    end
                    if (n_left == 3'd0) begin
                        if (n_acc == 32'd0) begin
                            n_phase = PH_OPCODE;
                        end else begin
                            n_skip  = n_acc;
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (r_skip != 32'd0) begin
                        n_skip = r_skip - 32'd1;
                    end
                    if (n_skip == 32'd0) begin
                        n_phase = PH_OPCODE;
                    end
                end
                default: begin
                    if (b <= OP_PUSH_MAX) begin
                        if (b >= OP_PUSHDATA1) begin
                            n_left  = 3'd1 << (b[1:0] - OP_PUSHDATA1[1:0]);
                            n_acc   = '0;
                            n_idx   = '0;
                            n_phase = PH_LENGTH;
                        end else if (b == 8'd0) begin
                            n_phase = PH_OPCODE;
                        end else begin
                            n_skip  = 32'(b);
                            n_phase = PH_SKIP;
                        end
                    end else if (b == OP_CHECKSIG || b == OP_CHECKSIGV ||
                                 (i_item.tapscript_mode && b == OP_CHECKSIGADD)) begin
                        chg_req = 1'b1;
                    end else if (b == OP_CHECKMS || b == OP_CHECKMSV) begin
                        chg_req = 1'b1;
                        if (i_item.accurate_mode && r_prev >= OP_SMALL_LO &&
                            r_prev <= OP_SMALL_HI) begin
                            chg_amt = 5'(r_prev - OP_SMALL_BASE);
                        end else begin
                            chg_amt = MULTISIG_DEFAULT;
                        end
                    end
                    n_prev = b;
                end
            endcase
        end
        if (chg_req && !r_ovf) begin
            if (sum > {1'b0, lim}) begin
                n_ovf = 1'b1;
            end else begin
                n_count = sum[COUNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPCODE;
            r_left  <= '0;
            r_idx   <= '0;
            r_acc   <= '0;
            r_skip  <= '0;
            r_prev  <= OP_NONE;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_step) begin
            if (i_item.last_byte) begin
                r_phase <= PH_OPCODE;
                r_left  <= '0;
                r_idx   <= '0;
                r_acc   <= '0;
                r_skip  <= '0;
                r_prev  <= OP_NONE;
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_left  <= n_left;
                r_idx   <= n_idx;
                r_acc   <= n_acc;
                r_skip  <= n_skip;
                r_prev  <= n_prev;
                r_count <= n_count;
                r_ovf   <= n_ovf;
            end
        end
    end

    assign count_wide              = 32'(n_count);
    assign o_result.sigop_count    = count_wide[SIGOP_W-1:0];
    assign o_result.limit_exceeded = n_ovf;

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LENGTH) |-> (r_left != 3'd0))
        else $error("length phase with no length bytes left");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.last_byte) |=>
            (r_count == '0 && !r_ovf && r_phase == PH_OPCODE && r_prev == OP_NONE))
        else $error("state not cleared after end of script");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf && !(i_step && i_item.last_byte)) |=> r_ovf)
        else $error("overflow flag dropped inside a script");

endmodule

`default_nettype wire

// File: design/script_sigop_counter.sv
// top level: input register, parser, result register and apb register block
`timescale 1ns / 1ps
`default_nettype none

// One script byte per beat, one beat accepted in every cycle but for the stall
// below. A beat is held in an input register and parsed from there; its result
// (only on the beat with tlast) is registered in the result register, shows on
// the master side and waits there until taken. s_axis_tready drops only while a
// tlast beat sits behind a result that has not been taken yet; other beats keep
// flowing past a waiting result. An empty script is a beat with tuser bit 0 low
// and tlast high. The limit register at byte address 0 resets to 80000.
module script_sigop_counter (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,  // script_byte
    input  wire logic                         s_axis_tlast,  // last_byte
    input  wire logic [2:0]                   s_axis_tuser,  // byte_present, accurate_mode,
                                                             // tapscript_mode
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic      [23:0]                  m_axis_tdata,  // sigop_count[19:0],
                                                             // limit_exceeded, zero pad
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ssc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ssc_pkg::DATA_W-1:0]   pwdata,
    output logic      [ssc_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);
    import ssc_pkg::*;

    logic               r_in_valid;
    t_item              r_in;
    logic               r_out_valid;
    t_result            r_out;
    t_result            res;
    logic               step;
    logic               s_beat;
    logic [LIMIT_W-1:0] sigop_limit;

    assign step          = r_in_valid && (!r_in.last_byte || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_beat) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_in.script_byte    <= s_axis_tdata;
            r_in.last_byte      <= s_axis_tlast;
            r_in.byte_present   <= s_axis_tuser[0];
            r_in.accurate_mode  <= s_axis_tuser[1];
            r_in.tapscript_mode <= s_axis_tuser[2];
        end
    end

    ssc_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_sigop_limit (sigop_limit)
    );

    ssc_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (r_in),
        .i_sigop_limit (sigop_limit),
        .o_result      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in.last_byte) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.limit_exceeded, r_out.sigop_count};

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in.last_byte) |=> r_out_valid)
        else $error("end of script beat gave no result");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_in.last_byte && r_out_valid && !m_axis_tready))
        else $error("input stalled without a waiting result");

    a_no_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> r_in_valid)
        else $error("parser stepped on an empty input register");

endmodule

`default_nettype wire

// File: dv/tb.sv
// self-checking testbench for the script signature-op counter, with random byte streams
`timescale 1ns / 1ps

module tb;
    import ssc_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    wire                 s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;   // script_byte
    logic                s_axis_tlast = 1'b0; // last_byte
    logic [2:0]          s_axis_tuser = '0;   // byte_present, accurate_mode, tapscript_mode
    wire                 m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    wire  [23:0]         m_axis_tdata;        // sigop_count[19:0], limit_exceeded, zero pad
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    wire  [DATA_W-1:0]   prdata;
    wire                 pready;

    script_sigop_counter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predicted parser state
    t_phase               scan_phase;
    logic [2:0]           len_left;
    logic [31:0]          len_acc;
    int unsigned          len_shift;
    logic [31:0]          skip_left;
    logic [7:0]           prev_op;
    logic [COUNT_BITS-1:0] sig_count;
    logic                 over_flag;
    logic [LIMIT_W-1:0]   limit_reg;

    t_item   pending_beats[$];
    t_item   script_q[$];
    t_result expected_counts[$];
    t_result want;

    int unsigned errors = 0;
    int unsigned beats_sent = 0;
    int unsigned items_queued = 0;
    int unsigned tx_gap = 0, tx_calm = 0, rx_gap = 0, rx_calm = 0;
    int unsigned hold_left = 0;
    logic        hold_armed = 1'b1;
    logic        gen_acc = 1'b0, gen_tap = 1'b0, gen_noise = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (errors < 40)
            $display("mismatch: %s", what);
        errors++;
    endtask

    task automatic clear_script();
        scan_phase = PH_OPCODE;
        len_left   = '0;
        len_acc    = '0;
        len_shift  = 0;
        skip_left  = '0;
        prev_op    = OP_NONE;
        sig_count  = '0;
        over_flag  = 1'b0;
    endtask

    task automatic add_sigops(input int unsigned amount);
        longint unsigned cap, lim;
        cap = (64'd1 << COUNT_BITS) - 1;
        lim = (limit_reg < cap) ? limit_reg : cap;
        if (!over_flag) begin
            if (sig_count > lim || amount > lim - sig_count)
                over_flag = 1'b1;
            else
                sig_count = sig_count + amount;
        end
    endtask

    task automatic enter_push(input logic [31:0] len);
        if (len == 0) begin
            scan_phase = PH_OPCODE;
        end else begin
            skip_left  = len;
            scan_phase = PH_SKIP;
        end
    endtask

    task automatic predict_beat(input logic [7:0] b, input logic present, input logic last,
                                input logic acc, input logic tap);
        int unsigned n;
        if (present) begin
            case (scan_phase)
                PH_LENGTH: begin
                    if (len_shift < 32)
                        len_acc = len_acc | (32'(b) << len_shift);
                    len_shift += 8;
                    if (len_left > 0)
                        len_left = len_left - 1;
                    if (len_left == 0)
                        enter_push(len_acc);
                end
                PH_SKIP: begin
                    if (skip_left > 0)
                        skip_left = skip_left - 1;
                    if (skip_left == 0)
                        scan_phase = PH_OPCODE;
                end
                default: begin
                    if (b <= OP_PUSH_MAX) begin
                        if (b >= OP_PUSHDATA1) begin
                            len_left   = 3'(1 << (b - OP_PUSHDATA1));
                            len_acc    = '0;
                            len_shift  = 0;
                            scan_phase = PH_LENGTH;
                        end else begin
                            enter_push(32'(b));
                        end
                    end else if (b == OP_CHECKSIG || b == OP_CHECKSIGV
                                 || (tap && b == OP_CHECKSIGADD)) begin
                        add_sigops(1);
                    end else if (b == OP_CHECKMS || b == OP_CHECKMSV) begin
                        n = MULTISIG_DEFAULT;
                        if (acc && prev_op >= OP_SMALL_LO && prev_op <= OP_SMALL_HI)
                            n = prev_op - OP_SMALL_BASE;
                        add_sigops(n);
                    end
                    prev_op = b;
                end
            endcase
        end
        if (last) begin
            expected_counts.push_back('{limit_exceeded: over_flag, sigop_count: sig_count});
            clear_script();
        end
    endtask

    function automatic int unsigned idle_len(inout int unsigned calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if (r < 3)
            calm = $urandom_range(40, 150);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_beat(s_axis_tdata, s_axis_tuser[0], s_axis_tlast,
                             s_axis_tuser[1], s_axis_tuser[2]);
                beats_sent <= beats_sent + 1;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                s_axis_tvalid <= 1'b1;
            end else if (tx_gap != 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                t_item nb;
                nb = pending_beats.pop_front();
                s_axis_tdata  <= nb.script_byte;
                s_axis_tlast  <= nb.last_byte;
                s_axis_tuser  <= {nb.tapscript_mode, nb.accurate_mode, nb.byte_present};
                s_axis_tvalid <= 1'b1;
                tx_gap = idle_len(tx_calm);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, once
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end else if (hold_armed && beats_sent >= 400) begin
            hold_left  <= 250;
            hold_armed <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_counts.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat %h", m_axis_tdata));
                end else begin
                    want = expected_counts.pop_front();
                    if (m_axis_tdata[SIGOP_W-1:0] !== want.sigop_count)
                        report_mismatch($sformatf("sigop_count %0d, predicted %0d",
                                        m_axis_tdata[SIGOP_W-1:0], want.sigop_count));
                    if (m_axis_tdata[SIGOP_W] !== want.limit_exceeded)
                        report_mismatch($sformatf("limit_exceeded %b, predicted %b",
                                        m_axis_tdata[SIGOP_W], want.limit_exceeded));
                end
            end
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready)
                    rx_gap = idle_len(rx_calm);
            end
        end
    end

    task automatic put_byte(input logic [7:0] b);
        if (gen_noise && $urandom_range(0, 99) < 6)
            script_q.push_back('{tapscript_mode: 1'($urandom), accurate_mode: 1'($urandom),
                                 byte_present: 1'b0, last_byte: 1'b0,
                                 script_byte: 8'($urandom)});
        if (gen_noise && $urandom_range(0, 99) < 8) begin
            gen_acc = 1'($urandom);
            gen_tap = 1'($urandom);
        end
        script_q.push_back('{tapscript_mode: gen_tap, accurate_mode: gen_acc,
                             byte_present: 1'b1, last_byte: 1'b0, script_byte: b});
    endtask

    task automatic close_script(input logic use_terminator);
        if (use_terminator || script_q.size() == 0)
            script_q.push_back('{tapscript_mode: 1'($urandom), accurate_mode: 1'($urandom),
                                 byte_present: 1'b0, last_byte: 1'b1,
                                 script_byte: 8'($urandom)});
        else
            script_q[script_q.size()-1].last_byte = 1'b1;
        foreach (script_q[k])
            pending_beats.push_back(script_q[k]);
        items_queued += script_q.size();
        script_q.delete();
    endtask

    task automatic queue_random_scripts(input int unsigned n_items);
        int unsigned target, n_ops, pick, len, wsel;
        target    = items_queued + n_items;
        gen_noise = 1'b1;
        while (items_queued < target) begin
            gen_acc = 1'($urandom);
            gen_tap = 1'($urandom);
            n_ops = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 10);
            for (int k = 0; k < n_ops; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 18) begin
                    put_byte(8'($urandom_range(OP_SMALL_LO, OP_SMALL_HI)));
                end else if (pick < 32) begin
                    case ($urandom_range(0, 2))
                        0: put_byte(OP_CHECKSIG);
                        1: put_byte(OP_CHECKSIGV);
                        default: put_byte(OP_CHECKSIGADD);
                    endcase
                end else if (pick < 46) begin
                    put_byte($urandom_range(0, 1) ? OP_CHECKMS : OP_CHECKMSV);
                end else if (pick < 60) begin
                    len = $urandom_range(0, 6);
                    put_byte(8'(len));
                    repeat (len) put_byte(8'($urandom));
                end else if (pick < 70) begin
                    wsel = $urandom_range(0, 2);
                    len  = $urandom_range(0, 5);
                    put_byte(OP_PUSHDATA1 + 8'(wsel));
                    for (int j = 0; j < (1 << wsel); j++)
                        put_byte((j == 0) ? 8'(len) : 8'h00);
                    repeat (len) put_byte(8'($urandom));
                end else if (pick < 85) begin
                    put_byte(8'($urandom));
                end else begin
                    put_byte(8'($urandom_range(OP_PUSH_MAX + 1, OP_NONE)));
                end
            end
            // push that runs off the end of the script
            if ($urandom_range(0, 9) == 0) begin
                put_byte(8'($urandom_range(8'h08, OP_PUSH_MAX)));
                repeat ($urandom_range(0, 2)) put_byte(8'($urandom));
            end
            close_script($urandom_range(0, 99) < 15);
        end
        gen_noise = 1'b0;
    endtask

    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        while ((pending_beats.size() != 0 || s_axis_tvalid || expected_counts.size() != 0)
               && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SIGOP_LIMIT, 2'b00};
        pwdata  <= {12'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        limit_reg = value;
    endtask

    initial begin
        limit_reg = LIMIT_RESET;
        clear_script();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed scripts at the reset limit
        close_script(1'b0);
        put_byte(OP_CHECKSIG); put_byte(OP_CHECKSIGV); close_script(1'b0);
        put_byte(OP_CHECKSIGADD); close_script(1'b0);
        gen_tap = 1'b1;
        put_byte(OP_CHECKSIGADD); close_script(1'b1);
        gen_tap = 1'b0;
        gen_acc = 1'b1;
        put_byte(OP_SMALL_HI); put_byte(OP_CHECKMSV); close_script(1'b0);
        put_byte(OP_SMALL_BASE); put_byte(OP_CHECKMS); close_script(1'b0);
        gen_acc = 1'b0;
        put_byte(OP_SMALL_LO); put_byte(OP_CHECKMS); close_script(1'b0);
        put_byte(8'h01); put_byte(OP_CHECKSIG); put_byte(OP_CHECKSIG); close_script(1'b0);
        put_byte(OP_PUSHDATA1 + 8'd1); put_byte(8'h01); put_byte(8'h00);
        put_byte(OP_CHECKSIG); put_byte(OP_CHECKSIG); close_script(1'b0);
        put_byte(OP_PUSH_MAX); put_byte(8'hff); close_script(1'b0);
        script_q.push_back('{tapscript_mode: 1'b0, accurate_mode: 1'b0, byte_present: 1'b0,
                             last_byte: 1'b0, script_byte: OP_CHECKSIG});
        put_byte(OP_CHECKSIGV); close_script(1'b0);
        queue_random_scripts(330);
        drain_results();

        write_limit('0);
        @(negedge i_clk);
        put_byte(OP_CHECKSIG); close_script(1'b0);
        queue_random_scripts(100);
        drain_results();

        write_limit({LIMIT_W{1'b1}});
        @(negedge i_clk);
        queue_random_scripts(350);
        drain_results();

        write_limit(LIMIT_W'(1));
        @(negedge i_clk);
        put_byte(OP_CHECKSIG); put_byte(OP_CHECKSIGV); close_script(1'b0);
        queue_random_scripts(150);
        drain_results();

        write_limit(LIMIT_W'(25));
        @(negedge i_clk);
        queue_random_scripts(200);
        drain_results();

        write_limit(LIMIT_W'($urandom_range(2, 60)));
        @(negedge i_clk);
        queue_random_scripts(150);
        drain_results();

        repeat (8) @(posedge i_clk);
        if (expected_counts.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_counts.size()));
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
